// ===== hdl/sorted_priority_queue_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared property templates for the queue's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication, disabled while reset is held
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes, and the types shared by the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PRIO_BITS   = 8;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_PEEK   = 2'd1,
        MODE_POP    = 2'd2,
        MODE_DELETE = 2'd3
    } t_spq_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_spq_status;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } t_spq_entry;

    // broadcast to every cell in the execute cycle
    typedef struct packed {
        logic                 insert;
        logic                 pop;
        logic                 delete_job;
        logic [ID_BITS-1:0]   key_id;
        logic [PRIO_BITS-1:0] key_prio;
    } t_spq_ctrl;

endpackage

`default_nettype wire

// ===== hdl/spq_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
    import spq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [ID_BITS-1:0]   job_id;
    logic [PRIO_BITS-1:0] priority_req;

    modport source (output valid, output mode, output job_id, output priority_req,
                    input ready);
    modport sink   (input valid, input mode, input job_id, input priority_req,
                    output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [ID_BITS-1:0]    head_job;
    logic [PRIO_BITS-1:0]  head_priority;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  queue_empty;

    modport source (output valid, output status, output head_job, output head_priority,
                    output entry_count, output queue_empty, input ready);
    modport sink   (input valid, input status, input head_job, input head_priority,
                    input entry_count, input queue_empty, output ready);
endinterface

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts right on insert, left on pop or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  spq_pkg::t_spq_ctrl   i_ctrl,
    input  wire                  i_occupied,
    input  wire                  i_left_le,
    input  spq_pkg::t_spq_entry  i_left,
    input  spq_pkg::t_spq_entry  i_right,
    input  wire                  i_seen,
    output logic                 o_le,
    output logic                 o_seen,
    output spq_pkg::t_spq_entry  o_entry
);
    import spq_pkg::*;

    t_spq_entry r_entry;
    t_spq_entry n_entry;
    logic       w_match;

    assign o_le    = i_occupied && (r_entry.prio <= i_ctrl.key_prio);
    assign w_match = i_occupied && (r_entry.id == i_ctrl.key_id);
    assign o_seen  = i_seen || w_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            // cells at or after the slot move right; the slot takes the new job
            if (!o_le) begin
                if (i_left_le) begin
                    n_entry.id   = i_ctrl.key_id;
                    n_entry.prio = i_ctrl.key_prio;
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end else if (i_ctrl.delete_job) begin
            // close the gap from the first match onward
            if (o_seen) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Sorted job list in a row of cells with insert, peek, pop and delete.
// ----------------------------------------------------------------------------
// Each request beat is latched at acceptance, then the whole cell row updates
// in the execute cycle, which also loads the result register. Request ready
// stays low from acceptance through the execute cycle, so a new beat is taken
// only once the previous one has executed. The row is a single shift chain, so
// the execute cycle holds while the result register still carries an
// unaccepted beat; one request can wait latched behind it, and ready stays low
// until that request executes. Entries are ordered by ascending priority, ties
// in arrival order; slot 0 is the head.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
    input  wire      i_clk,
    input  wire      i_rst_n,
    spq_req_if.sink  i_req,
    spq_rsp_if.source o_rsp
);
    import spq_pkg::*;

    logic                  r_busy;
    logic                  n_busy;
    t_spq_mode             r_mode;
    logic [ID_BITS-1:0]    r_job_id;
    logic [PRIO_BITS-1:0]  r_prio;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;

    logic                  r_out_valid;
    logic                  n_out_valid;
    t_spq_status           r_status;
    t_spq_status           n_status;
    logic [ID_BITS-1:0]    r_head_job;
    logic [ID_BITS-1:0]    n_head_job;
    logic [PRIO_BITS-1:0]  r_head_prio;
    logic [PRIO_BITS-1:0]  n_head_prio;

    logic                  w_accept;
    logic                  w_exec;
    logic                  w_full;
    logic                  w_empty;
    t_spq_ctrl             w_ctrl;

    t_spq_entry            w_entry [QUEUE_DEPTH];
    logic                  w_le    [QUEUE_DEPTH];
    logic                  w_seen  [QUEUE_DEPTH];

    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && !r_busy;
    assign w_exec      = r_busy && (!r_out_valid || o_rsp.ready);
    assign w_full      = (r_count == COUNT_BITS'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    always_comb begin
        w_ctrl.insert     = w_exec && (r_mode == MODE_INSERT) && !w_full;
        w_ctrl.pop        = w_exec && (r_mode == MODE_POP) && !w_empty;
        w_ctrl.delete_job = w_exec && (r_mode == MODE_DELETE);
        w_ctrl.key_id     = r_job_id;
        w_ctrl.key_prio   = r_prio;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic       w_occ;
        logic       w_left_le;
        logic       w_seen_in;
        t_spq_entry w_left;
        t_spq_entry w_right;

        assign w_occ = (r_count > COUNT_BITS'(g));

        if (g == 0) begin : g_head
            assign w_left_le = 1'b1;
            assign w_seen_in = 1'b0;
            assign w_left    = '0;
        end else begin : g_body
            assign w_left_le = w_le[g-1];
            assign w_seen_in = w_seen[g-1];
            assign w_left    = w_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_en       (w_exec),
            .i_ctrl     (w_ctrl),
            .i_occupied (w_occ),
            .i_left_le  (w_left_le),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_seen     (w_seen_in),
            .o_le       (w_le[g]),
            .o_seen     (w_seen[g]),
            .o_entry    (w_entry[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_head_job  = '0;
        n_head_prio = '0;
        case (r_mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + COUNT_BITS'(1);
                end
            end
            MODE_PEEK, MODE_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head_job  = w_entry[0].id;
                    n_head_prio = w_entry[0].prio;
                    if (r_mode == MODE_POP) begin
                        n_count = r_count - COUNT_BITS'(1);
                    end
                end
            end
            MODE_DELETE: begin
                if (w_seen[QUEUE_DEPTH-1]) begin
                    n_count = r_count - COUNT_BITS'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_exec) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (w_exec) begin
                r_count <= n_count;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= t_spq_mode'(i_req.mode);
            r_job_id <= i_req.job_id;
            r_prio   <= i_req.priority_req;
        end
        if (w_exec) begin
            r_status    <= n_status;
            r_head_job  <= n_head_job;
            r_head_prio <= n_head_prio;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.head_job      = r_head_job;
    assign o_rsp.head_priority = r_head_prio;
    assign o_rsp.entry_count   = r_count;
    assign o_rsp.queue_empty   = w_empty;

    `SPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= COUNT_BITS'(QUEUE_DEPTH))
    `SPQ_ASSERT_IMP(a_head_sorted, i_clk, i_rst_n, r_count > COUNT_BITS'(1), w_entry[0].prio <= w_entry[1].prio)
    `SPQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_busy && !i_req.ready)
    `SPQ_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, !w_exec, $stable(r_count))

endmodule

`default_nettype wire
